// ----- hw/rtl/wrhs_pkg.sv -----
`default_nettype none

package wrhs_pkg;

  localparam int unsigned DEF_HISTORY_DEPTH = 64;

  localparam int unsigned KH_W    = 16;
  localparam int unsigned PH_W    = 14;
  localparam int unsigned TEMP_W  = 12;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned INT_W   = 11;
  localparam int unsigned IVMS_W  = 27;
  localparam int unsigned ENTRY_W = KH_W + 2 * PH_W + TEMP_W + 1 + STAMP_W;

  // Entry layout in the history memory, low bit first
  localparam int unsigned E_PHR   = KH_W;
  localparam int unsigned E_PHS   = E_PHR + PH_W;
  localparam int unsigned E_TEMP  = E_PHS + PH_W;
  localparam int unsigned E_VALID = E_TEMP + TEMP_W;
  localparam int unsigned E_STAMP = E_VALID + 1;

  localparam logic [STAMP_W-1:0] HOUR_MS    = 32'd3600000;
  localparam logic [STAMP_W-1:0] DAY_MS     = 32'd86400000;
  localparam logic [STAMP_W-1:0] WEEK_MS    = 32'd604800000;
  localparam logic [15:0]        MS_PER_MIN = 16'd60000;
  localparam logic [INT_W-1:0]   INTERVAL_MIN = 11'd60;
  localparam logic [INT_W-1:0]   INTERVAL_MAX = 11'd1440;
  localparam logic [IVMS_W-1:0]  IVMS_RESET   = 27'd3600000;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_READ  = 2'd1,
    OP_STATS = 2'd2,
    OP_CLEAR = 2'd3
  } wrhs_op_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_RANGE      = 2'd1,
    ST_EMPTY      = 2'd2,
    ST_NONE_VALID = 2'd3
  } wrhs_status_e;

  typedef enum logic [1:0] {
    WIN_HOUR = 2'd0,
    WIN_DAY  = 2'd1,
    WIN_WEEK = 2'd2,
    WIN_ALL  = 2'd3
  } wrhs_win_e;

  typedef struct packed {
    logic [1:0]                opcode;
    logic [KH_W-1:0]           kh_in;
    logic [PH_W-1:0]           ph_ref_in;
    logic [PH_W-1:0]           ph_sample_in;
    logic signed [TEMP_W-1:0]  temp_in;
    logic [STAMP_W-1:0]        stamp_in;
    logic                      valid_in;
    logic [7:0]                age_index;
    logic [1:0]                window;
    logic [STAMP_W-1:0]        now_ms;
  } wrhs_item_t;

  typedef struct packed {
    logic [1:0]                status;
    logic                      measure_due;
    logic [COUNT_W-1:0]        count;
    logic [KH_W-1:0]           kh_value;
    logic [PH_W-1:0]           ph_ref_out;
    logic [PH_W-1:0]           ph_sample_out;
    logic signed [TEMP_W-1:0]  temp_out;
    logic [STAMP_W-1:0]        stamp_out;
    logic                      valid_out;
    logic [KH_W-1:0]           std_dev;
    logic [KH_W-1:0]           min_kh;
    logic [KH_W-1:0]           max_kh;
  } wrhs_res_t;

  typedef struct packed {
    logic accept;
    logic read_cap;
    logic walk_step;
    logic walk_fin;
    logic mul_step;
    logic div_start;
    logic div_var;
    logic take_mean;
    logic sqrt_start;
    logic take_std;
    logic out_load;
  } wrhs_cmd_t;

  typedef struct packed {
    logic walk_more;
    logic walk_done;
    logic stats_empty;
    logic mul_last;
    logic div_done;
    logic sqrt_done;
    logic out_free;
  } wrhs_sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/wrhs_if.sv -----
`default_nettype none

interface wrhs_in_if import wrhs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [1:0]                opcode;
  logic [KH_W-1:0]           kh_in;
  logic [PH_W-1:0]           ph_ref_in;
  logic [PH_W-1:0]           ph_sample_in;
  logic signed [TEMP_W-1:0]  temp_in;
  logic [STAMP_W-1:0]        stamp_in;
  logic                      valid_in;
  logic [7:0]                age_index;
  logic [1:0]                window;
  logic [STAMP_W-1:0]        now_ms;

  modport source (output valid, opcode, kh_in, ph_ref_in, ph_sample_in, temp_in, stamp_in,
                  valid_in, age_index, window, now_ms, input ready);
  modport sink (input valid, opcode, kh_in, ph_ref_in, ph_sample_in, temp_in, stamp_in,
                valid_in, age_index, window, now_ms, output ready);
endinterface

interface wrhs_out_if import wrhs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [1:0]                status;
  logic                      measure_due;
  logic [COUNT_W-1:0]        count;
  logic [KH_W-1:0]           kh_value;
  logic [PH_W-1:0]           ph_ref_out;
  logic [PH_W-1:0]           ph_sample_out;
  logic signed [TEMP_W-1:0]  temp_out;
  logic [STAMP_W-1:0]        stamp_out;
  logic                      valid_out;
  logic [KH_W-1:0]           std_dev;
  logic [KH_W-1:0]           min_kh;
  logic [KH_W-1:0]           max_kh;

  modport source (output valid, status, measure_due, count, kh_value, ph_ref_out,
                  ph_sample_out, temp_out, stamp_out, valid_out, std_dev, min_kh, max_kh,
                  input ready);
  modport sink (input valid, status, measure_due, count, kh_value, ph_ref_out,
                ph_sample_out, temp_out, stamp_out, valid_out, std_dev, min_kh, max_kh,
                output ready);
endinterface

interface wrhs_cfg_if import wrhs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [INT_W-1:0]  data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/windowed_reading_history_stats_core.sv -----
// Add and clear go straight to the output stage, read first waits for the memory read,
// and statistics walk the stored entries at one entry per cycle, then run the multiplier
// steps, two one-bit-per-cycle divisions and a square root.
// One transaction is in flight at a time; the next is taken once the result is queued
// in the output register, and that register holds while its last result is not taken.
// Async reset (rst_ni low) empties the history, memory left uncleared, interval 60 min.
`default_nettype none

module windowed_reading_history_stats_core import wrhs_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = DEF_HISTORY_DEPTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  wrhs_in_if.sink   in_ch,
  wrhs_out_if.source out_ch,
  wrhs_cfg_if.sink  cfg_ch
);

  wrhs_cmd_t  cmd;
  wrhs_sts_t  sts;
  wrhs_item_t item;
  wrhs_res_t  res;
  logic       out_valid;

  // Gather the input transaction into one bundle for the datapath
  always_comb begin
    item.opcode       = in_ch.opcode;
    item.kh_in        = in_ch.kh_in;
    item.ph_ref_in    = in_ch.ph_ref_in;
    item.ph_sample_in = in_ch.ph_sample_in;
    item.temp_in      = in_ch.temp_in;
    item.stamp_in     = in_ch.stamp_in;
    item.valid_in     = in_ch.valid_in;
    item.age_index    = in_ch.age_index;
    item.window       = in_ch.window;
    item.now_ms       = in_ch.now_ms;
  end

  // The user sends configuration writes only while idle (the block does not enforce it): take them at once
  assign cfg_ch.ready = 1'b1;

  wrhs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_op_i    (in_ch.opcode),
    .in_ready_o (in_ch.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  wrhs_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .item_i      (item),
    .cfg_we_i    (cfg_ch.valid),
    .cfg_data_i  (cfg_ch.data),
    .out_o       (res),
    .out_valid_o (out_valid),
    .out_ready_i (out_ch.ready)
  );

  // Drive the result channel from the output register
  assign out_ch.valid         = out_valid;
  assign out_ch.status        = res.status;
  assign out_ch.measure_due   = res.measure_due;
  assign out_ch.count         = res.count;
  assign out_ch.kh_value      = res.kh_value;
  assign out_ch.ph_ref_out    = res.ph_ref_out;
  assign out_ch.ph_sample_out = res.ph_sample_out;
  assign out_ch.temp_out      = res.temp_out;
  assign out_ch.stamp_out     = res.stamp_out;
  assign out_ch.valid_out     = res.valid_out;
  assign out_ch.std_dev       = res.std_dev;
  assign out_ch.min_kh        = res.min_kh;
  assign out_ch.max_kh        = res.max_kh;

  // A taken transaction leaves the idle state, so ready drops next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input taken twice in a row");

  // Divider completions are always consumed by the sequencer
  a_div_done_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.div_done |-> (cmd.take_mean || cmd.sqrt_start))
    else $error("divider result dropped");

  // Empty or invalid windows report no statistics
  a_empty_stats: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && (out_ch.status == ST_EMPTY || out_ch.status == ST_NONE_VALID))
      |-> (out_ch.count == '0 && out_ch.std_dev == '0 && out_ch.kh_value == '0))
    else $error("statistics on empty window");

endmodule

`default_nettype wire

// ----- hw/rtl/wrhs_ram.sv -----
`default_nettype none

module wrhs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]                      wdata_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hw/rtl/wrhs_div.sv -----
`default_nettype none

module wrhs_div #(
  parameter int unsigned DW = 46,
  parameter int unsigned VW = 14
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [DW-1:0] dividend_i,
  input  wire logic [VW-1:0] divisor_i,
  output logic [DW-1:0]      quo_o,
  output logic               done_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic [DW-1:0] quo_q;
  logic [VW-1:0] rem_q, div_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [VW:0]   trial;
  logic          fits;

  // One quotient bit per cycle, restoring
  always_comb begin
    trial = {rem_q, quo_q[DW-1]};
    fits  = trial >= {1'b0, div_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(DW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? VW'(trial - {1'b0, div_q}) : trial[VW-1:0];
      quo_q <= {quo_q[DW-2:0], fits};
    end
  end

  assign quo_o  = quo_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

// ----- hw/rtl/wrhs_sqrt.sv -----
`default_nettype none

module wrhs_sqrt (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] val_i,
  output logic [15:0]      root_o,
  output logic             done_o
);

  logic [31:0] val_q;
  logic [19:0] rem_q;
  logic [15:0] root_q;
  logic [4:0]  cnt_q;
  logic        busy_q, done_q;
  logic [19:0] part, trial;
  logic        fits;

  // Two radicand bits per cycle, one root bit
  always_comb begin
    part  = {rem_q[17:0], val_q[31:30]};
    trial = {2'b00, root_q, 2'b01};
    fits  = part >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd15) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q  <= val_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      val_q  <= {val_q[29:0], 2'b00};
      rem_q  <= fits ? (part - trial) : part;
      root_q <= {root_q[14:0], fits};
    end
  end

  assign root_o = root_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

// ----- hw/rtl/wrhs_dp.sv -----
`default_nettype none

module wrhs_dp import wrhs_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = DEF_HISTORY_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire wrhs_cmd_t        cmd_i,
  output wrhs_sts_t             sts_o,
  input  wire wrhs_item_t       item_i,
  input  wire logic             cfg_we_i,
  input  wire logic [INT_W-1:0] cfg_data_i,
  output wrhs_res_t             out_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i
);

  localparam int unsigned IW   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned NW   = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned SUMW = KH_W + NW;
  localparam int unsigned SQW  = 2 * KH_W + NW;
  localparam int unsigned NUMW = SQW + NW;
  localparam int unsigned NNW  = 2 * NW;
  localparam int unsigned LOW  = SQW / 2;
  localparam int unsigned HIW  = SQW - LOW;
  localparam int unsigned MW   = (SUMW > HIW) ? SUMW : HIW;
  localparam logic [IW:0] DEPTH_L = (IW + 1)'(HISTORY_DEPTH);

  function automatic logic [IW-1:0] wrap_idx(input logic [IW:0] v);
    wrap_idx = (v >= DEPTH_L) ? IW'(v - DEPTH_L) : v[IW-1:0];
  endfunction

  // Ring state
  logic [IW-1:0]     oldest_q, ptr_q;
  logic [NW-1:0]     count_q, remain_q;
  logic [STAMP_W-1:0] last_add_q;
  logic [IVMS_W-1:0] ivms_q;
  logic              issued_q, range_q, out_valid_q;
  logic [1:0]        mstep_q;

  // Working registers
  logic [STAMP_W-1:0] now_q;
  logic [1:0]         win_q;
  logic [NW-1:0]      n_q, inwin_q;
  logic [SUMW-1:0]    sum_q;
  logic [SQW-1:0]     sumsq_q;
  logic [KH_W-1:0]    min_q, max_q;
  logic [LOW+NW-1:0]  p_lo_q;
  logic [HIW+NW-1:0]  p_hi_q;
  logic [2*SUMW-1:0]  sq_q;
  logic [NNW-1:0]     nn_q;
  wrhs_res_t          res_q, out_q;
  wrhs_res_t          res_init, out_next;

  wrhs_op_e          op;
  logic              full, in_range, ram_we;
  logic [IW-1:0]     add_slot, rd_slot, ram_addr;
  logic [NW-1:0]     rd_off, count_next;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  logic [KH_W-1:0]   r_kh;
  logic [STAMP_W-1:0] r_age;
  logic              r_inwin;
  logic [MW-1:0]     mul_a, mul_b;
  logic [2*MW-1:0]   prod;
  logic [NUMW-1:0]   num, div_dividend, div_quo;
  logic [NNW-1:0]    div_divisor;
  logic              div_done, sqrt_done;
  logic [15:0]       root;
  logic [INT_W-1:0]  cfg_sat;

  assign op       = wrhs_op_e'(item_i.opcode);
  assign full     = count_q == NW'(HISTORY_DEPTH);
  assign add_slot = full ? oldest_q : wrap_idx({1'b0, oldest_q} + (IW + 1)'(count_q));
  assign in_range = 32'(item_i.age_index) < 32'(count_q);
  assign rd_off   = count_q - NW'(1) - NW'(item_i.age_index);
  assign rd_slot  = wrap_idx({1'b0, oldest_q} + (IW + 1)'(rd_off));
  assign count_next = full ? count_q : count_q + NW'(1);

  assign ram_wdata = {item_i.stamp_in, item_i.valid_in, item_i.temp_in,
                      item_i.ph_sample_in, item_i.ph_ref_in, item_i.kh_in};
  assign ram_we    = cmd_i.accept && (op == OP_ADD);

  always_comb begin
    ram_addr = add_slot;
    if (cmd_i.walk_step) begin
      ram_addr = ptr_q;
    end else if (cmd_i.accept && (op == OP_READ)) begin
      ram_addr = rd_slot;
    end
  end

  wrhs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Window test of the entry that arrives from memory
  assign r_kh  = ram_rdata[KH_W-1:0];
  assign r_age = now_q - ram_rdata[E_STAMP +: STAMP_W];

  always_comb begin
    case (win_q)
      WIN_HOUR: r_inwin = r_age < HOUR_MS;
      WIN_DAY:  r_inwin = r_age < DAY_MS;
      WIN_WEEK: r_inwin = r_age < WEEK_MS;
      default:  r_inwin = 1'b1;
    endcase
  end

  // Shared multiplier, one product per step
  always_comb begin
    case (mstep_q)
      2'd0: begin
        mul_a = MW'(n_q);
        mul_b = MW'(sumsq_q[LOW-1:0]);
      end
      2'd1: begin
        mul_a = MW'(n_q);
        mul_b = MW'(sumsq_q[SQW-1:LOW]);
      end
      2'd2: begin
        mul_a = MW'(sum_q);
        mul_b = MW'(sum_q);
      end
      default: begin
        mul_a = MW'(n_q);
        mul_b = MW'(n_q);
      end
    endcase
  end

  assign prod = mul_a * mul_b;
  assign num  = (NUMW'(p_hi_q) << LOW) + NUMW'(p_lo_q) - NUMW'(sq_q);

  assign div_dividend = cmd_i.div_var ? num : NUMW'(sum_q);
  assign div_divisor  = cmd_i.div_var ? nn_q : NNW'(n_q);

  wrhs_div #(
    .DW (NUMW),
    .VW (NNW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quo_o      (div_quo),
    .done_o     (div_done)
  );

  wrhs_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sqrt_start),
    .val_i   (div_quo[31:0]),
    .root_o  (root),
    .done_o  (sqrt_done)
  );

  always_comb begin
    cfg_sat = cfg_data_i;
    if (cfg_data_i < INTERVAL_MIN) begin
      cfg_sat = INTERVAL_MIN;
    end else if (cfg_data_i > INTERVAL_MAX) begin
      cfg_sat = INTERVAL_MAX;
    end
  end

  // Result seed for a new transaction: zero fields, count by opcode
  always_comb begin
    res_init = '0;
    case (op)
      OP_ADD:  res_init.count = COUNT_W'(count_next);
      OP_READ: res_init.count = COUNT_W'(count_q);
      default: res_init.count = '0;
    endcase
  end

  always_comb begin
    out_next             = res_q;
    out_next.measure_due = (now_q - last_add_q) >= STAMP_W'(ivms_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q    <= '0;
      count_q     <= '0;
      last_add_q  <= '0;
      ivms_q      <= IVMS_RESET;
      ptr_q       <= '0;
      remain_q    <= '0;
      issued_q    <= 1'b0;
      range_q     <= 1'b0;
      mstep_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      issued_q <= cmd_i.walk_step;
      if (cfg_we_i) begin
        ivms_q <= IVMS_W'(32'(cfg_sat) * 32'(MS_PER_MIN));
      end
      if (cmd_i.accept) begin
        range_q <= in_range;
        mstep_q <= '0;
        case (op)
          OP_ADD: begin
            last_add_q <= item_i.now_ms;
            count_q    <= count_next;
            if (full) begin
              oldest_q <= wrap_idx({1'b0, oldest_q} + (IW + 1)'(1));
            end
          end
          OP_STATS: begin
            ptr_q    <= oldest_q;
            remain_q <= count_q;
          end
          OP_CLEAR: begin
            count_q  <= '0;
            oldest_q <= '0;
          end
          default: ;
        endcase
      end
      if (cmd_i.walk_step) begin
        ptr_q    <= wrap_idx({1'b0, ptr_q} + (IW + 1)'(1));
        remain_q <= remain_q - NW'(1);
      end
      if (cmd_i.mul_step) begin
        mstep_q <= mstep_q + 2'd1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      now_q   <= item_i.now_ms;
      win_q   <= item_i.window;
      n_q     <= '0;
      inwin_q <= '0;
      sum_q   <= '0;
      sumsq_q <= '0;
      min_q   <= '1;
      max_q   <= '0;
      res_q   <= res_init;
    end
    if (issued_q && r_inwin) begin
      inwin_q <= inwin_q + NW'(1);
      if (ram_rdata[E_VALID]) begin
        n_q     <= n_q + NW'(1);
        sum_q   <= sum_q + SUMW'(r_kh);
        sumsq_q <= sumsq_q + SQW'(32'(r_kh) * 32'(r_kh));
        if (r_kh < min_q) begin
          min_q <= r_kh;
        end
        if (r_kh > max_q) begin
          max_q <= r_kh;
        end
      end
    end
    if (cmd_i.read_cap) begin
      if (range_q) begin
        res_q.kh_value      <= r_kh;
        res_q.ph_ref_out    <= ram_rdata[E_PHR +: PH_W];
        res_q.ph_sample_out <= ram_rdata[E_PHS +: PH_W];
        res_q.temp_out      <= ram_rdata[E_TEMP +: TEMP_W];
        res_q.stamp_out     <= ram_rdata[E_STAMP +: STAMP_W];
        res_q.valid_out     <= ram_rdata[E_VALID];
      end else begin
        res_q.status <= ST_RANGE;
      end
    end
    if (cmd_i.walk_fin) begin
      if (inwin_q == '0) begin
        res_q.status <= ST_EMPTY;
      end else if (n_q == '0) begin
        res_q.status <= ST_NONE_VALID;
      end else begin
        res_q.count  <= COUNT_W'(n_q);
        res_q.min_kh <= min_q;
        res_q.max_kh <= max_q;
      end
    end
    if (cmd_i.mul_step) begin
      case (mstep_q)
        2'd0:    p_lo_q <= (LOW + NW)'(prod);
        2'd1:    p_hi_q <= (HIW + NW)'(prod);
        2'd2:    sq_q   <= (2 * SUMW)'(prod);
        default: nn_q   <= NNW'(prod);
      endcase
    end
    if (cmd_i.take_mean) begin
      res_q.kh_value <= div_quo[KH_W-1:0];
    end
    if (cmd_i.take_std) begin
      res_q.std_dev <= root;
    end
    if (cmd_i.out_load) begin
      out_q <= out_next;
    end
  end

  always_comb begin
    sts_o.walk_more   = remain_q != '0;
    sts_o.walk_done   = (remain_q == '0) && !issued_q;
    sts_o.stats_empty = (inwin_q == '0) || (n_q == '0);
    sts_o.mul_last    = mstep_q == 2'd3;
    sts_o.div_done    = div_done;
    sts_o.sqrt_done   = sqrt_done;
    sts_o.out_free    = !out_valid_q || out_ready_i;
  end

  assign out_o       = out_q;
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ----- hw/rtl/wrhs_ctrl.sv -----
`default_nettype none

module wrhs_ctrl import wrhs_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic [1:0] in_op_i,
  output logic           in_ready_o,
  input  wire wrhs_sts_t sts_i,
  output wrhs_cmd_t      cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_RDWAIT = 8'b0000_0010,
    S_WALK   = 8'b0000_0100,
    S_MUL    = 8'b0000_1000,
    S_DIVM   = 8'b0001_0000,
    S_DIVV   = 8'b0010_0000,
    S_SQRT   = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } wrhs_state_e;

  wrhs_state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          case (wrhs_op_e'(in_op_i))
            OP_READ:  state_d = S_RDWAIT;
            OP_STATS: state_d = S_WALK;
            default:  state_d = S_DONE;
          endcase
        end
      end
      S_RDWAIT: begin
        cmd_o.read_cap = 1'b1;
        state_d        = S_DONE;
      end
      S_WALK: begin
        cmd_o.walk_step = sts_i.walk_more;
        if (sts_i.walk_done) begin
          cmd_o.walk_fin = 1'b1;
          state_d        = sts_i.stats_empty ? S_DONE : S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul_step = 1'b1;
        if (sts_i.mul_last) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIVM;
        end
      end
      S_DIVM: begin
        if (sts_i.div_done) begin
          cmd_o.take_mean = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.div_var   = 1'b1;
          state_d         = S_DIVV;
        end
      end
      S_DIVV: begin
        if (sts_i.div_done) begin
          cmd_o.sqrt_start = 1'b1;
          state_d          = S_SQRT;
        end
      end
      S_SQRT: begin
        if (sts_i.sqrt_done) begin
          cmd_o.take_std = 1'b1;
          state_d        = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire
